### src/iecr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ICMP echo responder package
// Shared constants, the packet summary record and the one's-complement adder.
// ----------------------------------------------------------------------------
package iecr_pkg;

	localparam logic [15:0] ICMP_START   = 16'd20;
	localparam logic [15:0] MIN_TOTAL    = 16'd21;
	localparam logic [7:0]  ECHO_REQUEST = 8'd8;
	localparam logic [7:0]  ECHO_REPLY   = 8'd0;
	localparam int          QUEUE_DEPTH  = 4;

	typedef enum logic [1:0] {
		ACT_REPLY      = 2'd0,
		ACT_DROP_SHORT = 2'd1,
		ACT_DROP_REPLY = 2'd2,
		ACT_DROP_OTHER = 2'd3
	} action_t;

	typedef struct packed {
		logic        short_pkt;
		logic        truncated;
		logic [7:0]  kind;
		logic [15:0] total_length;
		logic [15:0] sum;
		logic [7:0]  held;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
	} summary_t;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage
`default_nettype wire

### src/icmp_echo_responder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Accepts one packet byte every clock cycle while full is low.
// On the last accepted byte the packet summary is written into the queue;
// the decision record is then loaded into the output register once it is free.
// Full rises only when DEPTH decisions (QUEUE_DEPTH by default) wait behind an unread result.
// Reset is asynchronous and clears all packet state, the queue and valid_q.
// ----------------------------------------------------------------------------
// ICMP echo responder core
// Classifies ICMP packets and produces echo reply decisions with checksums.
// ----------------------------------------------------------------------------
module icmp_echo_responder_core
	import iecr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  packet_byte,
	input  wire logic        last_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       action,
	output logic [15:0]      icmp_checksum,
	output logic [31:0]      reply_source,
	output logic [31:0]      reply_destination,
	output logic [15:0]      icmp_length
);

	logic     accept;
	logic     sum_push;
	summary_t sum_data;
	summary_t q_data;
	logic     q_rd;
	logic     q_empty;

	assign accept = push && !full;

	iecr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.packet_byte (packet_byte),
		.last_byte   (last_byte),
		.sum_push    (sum_push),
		.sum_data    (sum_data)
	);

	iecr_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (sum_push),
		.wr_data (sum_data),
		.rd      (q_rd),
		.rd_data (q_data),
		.full    (full),
		.empty   (q_empty)
	);

	iecr_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_data            (q_data),
		.q_rd              (q_rd),
		.empty             (empty),
		.pop               (pop),
		.action            (action),
		.icmp_checksum     (icmp_checksum),
		.reply_source      (reply_source),
		.reply_destination (reply_destination),
		.icmp_length       (icmp_length)
	);

endmodule
`default_nettype wire

### src/iecr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ICMP echo responder front end
// Absorbs packet bytes, captures header fields and builds the running sum.
// ----------------------------------------------------------------------------
module iecr_front
	import iecr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire logic [7:0] packet_byte,
	input  wire logic     last_byte,
	output logic          sum_push,
	output summary_t      sum_data
);

	logic [15:0] count_q;
	logic [15:0] total_q;
	logic [15:0] sum_q;
	logic [7:0]  held_q;
	logic [7:0]  kind_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;

	logic [15:0] total_n;
	logic [15:0] sum_n;
	logic [7:0]  held_n;
	logic [7:0]  kind_n;
	logic [31:0] src_n;
	logic [31:0] dst_n;
	logic        in_icmp;
	logic [7:0]  v;

	always_comb begin
		total_n = total_q;
		src_n   = src_q;
		dst_n   = dst_q;
		kind_n  = kind_q;
		sum_n   = sum_q;
		held_n  = held_q;
		if (count_q == 16'd2) begin
			total_n[15:8] = packet_byte;
		end else if (count_q == 16'd3) begin
			total_n[7:0] = packet_byte;
		end else if (count_q >= 16'd12 && count_q <= 16'd15) begin
			src_n = {src_q[23:0], packet_byte};
		end else if (count_q >= 16'd16 && count_q <= 16'd19) begin
			dst_n = {dst_q[23:0], packet_byte};
		end else if (count_q == ICMP_START) begin
			kind_n = packet_byte;
		end
		in_icmp = (count_q >= ICMP_START) && (count_q < total_n);
		// The type byte and the checksum field count as zero.
		if (count_q == ICMP_START || count_q == ICMP_START + 16'd2
				|| count_q == ICMP_START + 16'd3) begin
			v = 8'd0;
		end else begin
			v = packet_byte;
		end
		if (in_icmp) begin
			if (!count_q[0]) begin
				held_n = v;
			end else begin
				sum_n = ones_add(sum_q, {held_q, v});
			end
		end
	end

	assign sum_push = accept && last_byte;

	always_comb begin
		sum_data.short_pkt    = (count_q < ICMP_START) || (total_n < MIN_TOTAL);
		sum_data.truncated    = ({1'b0, count_q} + 17'd1) < {1'b0, total_n};
		sum_data.kind         = kind_n;
		sum_data.total_length = total_n;
		sum_data.sum          = sum_n;
		sum_data.held         = held_n;
		sum_data.src_addr     = src_n;
		sum_data.dst_addr     = dst_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			sum_q   <= '0;
			held_q  <= '0;
			kind_q  <= '0;
			src_q   <= '0;
			dst_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
				total_q <= '0;
				sum_q   <= '0;
				held_q  <= '0;
				kind_q  <= '0;
				src_q   <= '0;
				dst_q   <= '0;
			end else begin
				if (count_q != 16'hFFFF) begin
					count_q <= count_q + 16'd1;
				end
				total_q <= total_n;
				sum_q   <= sum_n;
				held_q  <= held_n;
				kind_q  <= kind_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
			end
		end
	end

endmodule
`default_nettype wire

### src/iecr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ICMP echo responder summary queue
// Short first-in first-out queue of packet summaries between front and back.
// ----------------------------------------------------------------------------
module iecr_queue
	import iecr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr,
	input  wire summary_t wr_data,
	input  wire logic     rd,
	output summary_t      rd_data,
	output logic          full,
	output logic          empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	summary_t        mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");
	assert property (@(posedge clk) disable iff (!arst_n) wr |-> !full || rd)
		else $error("write into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) rd |-> !empty)
		else $error("read from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count lost a write");

endmodule
`default_nettype wire

### src/iecr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ICMP echo responder back end
// Turns a packet summary into a decision record held in the output register.
// ----------------------------------------------------------------------------
module iecr_back
	import iecr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_empty,
	input  wire summary_t q_data,
	output logic          q_rd,
	output logic          empty,
	input  wire logic     pop,
	output logic [1:0]    action,
	output logic [15:0]   icmp_checksum,
	output logic [31:0]   reply_source,
	output logic [31:0]   reply_destination,
	output logic [15:0]   icmp_length
);

	logic        valid_q;
	action_t     act_n;
	logic [15:0] sum_fin;
	logic [15:0] len_n;

	always_comb begin
		priority if (q_data.short_pkt) begin
			act_n = ACT_DROP_SHORT;
		end else if (q_data.kind == ECHO_REQUEST) begin
			act_n = q_data.truncated ? ACT_DROP_SHORT : ACT_REPLY;
		end else if (q_data.kind == ECHO_REPLY) begin
			act_n = ACT_DROP_REPLY;
		end else begin
			act_n = ACT_DROP_OTHER;
		end
		len_n = q_data.total_length - ICMP_START;
		// An odd ICMP length leaves a lone high byte padded with zero.
		sum_fin = len_n[0] ? ones_add(q_data.sum, {q_data.held, 8'd0}) : q_data.sum;
	end

	assign q_rd  = !q_empty && (!valid_q || pop);
	assign empty = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			action <= act_n;
			if (act_n == ACT_REPLY) begin
				icmp_checksum     <= ~sum_fin;
				reply_source      <= q_data.dst_addr;
				reply_destination <= q_data.src_addr;
				icmp_length       <= len_n;
			end else begin
				icmp_checksum     <= '0;
				reply_source      <= '0;
				reply_destination <= '0;
				icmp_length       <= '0;
			end
		end
	end

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP echo responder testbench
// Streams IPv4/ICMP packets byte by byte into the core, predicts every
// decision record and compares each popped record field by field, under
// sender gaps, receiver stalls and a long receiver hold.
// ----------------------------------------------------------------------------
module testbench;
	import iecr_pkg::*;

	typedef bit [7:0] octets_t[$];

	typedef struct {
		action_t     act;
		bit [15:0]   csum;
		bit [31:0]   rsrc;
		bit [31:0]   rdst;
		bit [15:0]   ilen;
	} echo_decision_t;

	class echo_decision_tracker;
		bit [15:0]      seen_count;
		bit [15:0]      total_len;
		bit [15:0]      run_sum;
		bit [7:0]       held;
		bit [7:0]       kind;
		bit [31:0]      src;
		bit [31:0]      dst;
		echo_decision_t pending_decisions[$];
		int unsigned    failures;
		int unsigned    bytes_in;
		int unsigned    decisions_out;
		int unsigned    per_action[4];

		function new();
			failures = 0;
			bytes_in = 0;
			decisions_out = 0;
			foreach (per_action[i]) per_action[i] = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			seen_count = 0;
			total_len = 0;
			run_sum = 0;
			held = 0;
			kind = 0;
			src = 0;
			dst = 0;
		endfunction

		function bit [15:0] fold_add(bit [15:0] a, bit [15:0] b);
			bit [16:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[15:0] + {15'd0, s[16]};
		endfunction

		function void absorb_byte(bit [7:0] b, bit last);
			int unsigned    pos;
			int unsigned    got;
			int unsigned    ilen;
			bit [7:0]       v;
			bit [15:0]      s;
			echo_decision_t d;
			pos = seen_count;
			if (pos == 2) begin
				total_len[15:8] = b;
			end else if (pos == 3) begin
				total_len[7:0] = b;
			end else if (pos >= 12 && pos <= 15) begin
				src = {src[23:0], b};
			end else if (pos >= 16 && pos <= 19) begin
				dst = {dst[23:0], b};
			end else if (pos == ICMP_START) begin
				kind = b;
			end
			if (pos >= ICMP_START && pos < total_len) begin
				// The type byte and the checksum field enter the sum as zero.
				v = (pos == ICMP_START || pos == ICMP_START + 2 || pos == ICMP_START + 3) ?
					8'h00 : b;
				if (((pos - ICMP_START) & 1) == 0) begin
					held = v;
				end else begin
					run_sum = fold_add(run_sum, {held, v});
				end
			end
			got = pos + 1;
			if (seen_count != 16'hFFFF) seen_count++;
			bytes_in++;
			if (!last) return;
			d.csum = 0;
			d.rsrc = 0;
			d.rdst = 0;
			d.ilen = 0;
			if (got < MIN_TOTAL || total_len < MIN_TOTAL) begin
				d.act = ACT_DROP_SHORT;
			end else if (kind == ECHO_REQUEST) begin
				d.act = (got < total_len) ? ACT_DROP_SHORT : ACT_REPLY;
			end else if (kind == ECHO_REPLY) begin
				d.act = ACT_DROP_REPLY;
			end else begin
				d.act = ACT_DROP_OTHER;
			end
			if (d.act == ACT_REPLY) begin
				ilen = total_len - ICMP_START;
				s = run_sum;
				if (ilen[0]) s = fold_add(s, {held, 8'h00});
				d.csum = ~s;
				d.rsrc = dst;
				d.rdst = src;
				d.ilen = ilen[15:0];
			end
			pending_decisions.push_back(d);
			clear_packet();
		endfunction

		function void compare_decision(logic [1:0] a, logic [15:0] c, logic [31:0] rs,
				logic [31:0] rd, logic [15:0] l);
			echo_decision_t d;
			if (pending_decisions.size() == 0) begin
				$error("Unexpected decision record with action %0d.", a);
				failures++;
				return;
			end
			d = pending_decisions.pop_front();
			decisions_out++;
			per_action[d.act]++;
			if (a !== d.act) begin
				$error("action: expected %0d, got %0d", d.act, a);
				failures++;
			end
			if (c !== d.csum) begin
				$error("icmp_checksum: expected %h, got %h", d.csum, c);
				failures++;
			end
			if (rs !== d.rsrc) begin
				$error("reply_source: expected %h, got %h", d.rsrc, rs);
				failures++;
			end
			if (rd !== d.rdst) begin
				$error("reply_destination: expected %h, got %h", d.rdst, rd);
				failures++;
			end
			if (l !== d.ilen) begin
				$error("icmp_length: expected %0d, got %0d", d.ilen, l);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return pending_decisions.size();
		endfunction
	endclass

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  packet_byte;
	logic        last_byte;
	logic        empty;
	logic        pop;
	logic [1:0]  action;
	logic [15:0] icmp_checksum;
	logic [31:0] reply_source;
	logic [31:0] reply_destination;
	logic [15:0] icmp_length;

	echo_decision_tracker tracker = new();
	int          sender_idle_pct;
	int          receiver_stall_pct;
	int          hold_request;
	int          quiet_cycles;
	int unsigned full_cycles;

	icmp_echo_responder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.packet_byte(packet_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.action(action),
		.icmp_checksum(icmp_checksum),
		.reply_source(reply_source),
		.reply_destination(reply_destination),
		.icmp_length(icmp_length)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		packet_byte = 8'h00;
		last_byte = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_request = 0;
		quiet_cycles = 0;
		full_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// fill: 0 random content, 1 all zeros, 2 all ones (length and type kept)
	function automatic octets_t build_packet(int unsigned nbytes, bit [15:0] total_field,
			bit [7:0] kind, int fill);
		octets_t pkt;
		bit [7:0] b;
		for (int unsigned i = 0; i < nbytes; i++) begin
			b = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom_range(0, 255));
			if (i == 2) b = total_field[15:8];
			if (i == 3) b = total_field[7:0];
			if (i == ICMP_START) b = kind;
			pkt.push_back(b);
		end
		return pkt;
	endfunction

	task automatic send_byte(bit [7:0] b, bit last);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		packet_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (full);
		tracker.absorb_byte(b, last);
	endtask

	task automatic send_packet(octets_t pkt);
		foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	task automatic send_random_packet(output int unsigned sent);
		int          r;
		int unsigned total;
		int unsigned nbytes;
		bit [7:0]    kind;
		r = $urandom_range(0, 99);
		kind = ($urandom_range(0, 99) < 85) ? ECHO_REQUEST :
			($urandom_range(0, 1) ? ECHO_REPLY : 8'($urandom_range(0, 255)));
		if (r < 70) begin
			total = ICMP_START + $urandom_range(1, 40);
			nbytes = total;
		end else if (r < 80) begin
			total = ICMP_START + $urandom_range(1, 40);
			nbytes = $urandom_range(0, 1) ? total + $urandom_range(1, 10) :
				total - $urandom_range(1, 10);
		end else if (r < 90) begin
			total = $urandom_range(0, 70);
			nbytes = $urandom_range(1, 30);
		end else begin
			total = $urandom_range(0, 65535);
			nbytes = $urandom_range(1, 60);
			kind = 8'($urandom_range(0, 255));
		end
		send_packet(build_packet(nbytes, total[15:0], kind, 0));
		sent = nbytes;
	endtask

	initial begin
		int unsigned sent;
		int unsigned phase_bytes;
		@(posedge arst_n);
		@(posedge clk);

		send_packet(build_packet(1, 16'd0, ECHO_REQUEST, 0));
		send_packet(build_packet(20, 16'd20, ECHO_REQUEST, 0));
		send_packet(build_packet(21, 16'd20, ECHO_REQUEST, 0));
		send_packet(build_packet(21, 16'd21, ECHO_REQUEST, 0));
		send_packet(build_packet(28, 16'd28, ECHO_REQUEST, 0));
		send_packet(build_packet(29, 16'd29, ECHO_REQUEST, 0));
		send_packet(build_packet(30, 16'd40, ECHO_REQUEST, 0));
		send_packet(build_packet(45, 16'd30, ECHO_REQUEST, 0));
		send_packet(build_packet(28, 16'd28, ECHO_REPLY, 0));
		send_packet(build_packet(28, 16'd28, 8'hFF, 0));
		send_packet(build_packet(24, 16'd24, 8'd13, 0));
		send_packet(build_packet(22, 16'd20, ECHO_REPLY, 0));
		send_packet(build_packet(60, 16'd60, ECHO_REQUEST, 2));
		send_packet(build_packet(61, 16'd61, ECHO_REQUEST, 2));
		send_packet(build_packet(40, 16'd40, ECHO_REQUEST, 1));
		send_packet(build_packet(21, 16'd21, ECHO_REQUEST, 2));
		send_packet(build_packet(30, 16'hFFFF, ECHO_REQUEST, 2));
		send_packet(build_packet(30, 16'hFFFF, 8'hFF, 0));

		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 56 : 18) : 0;
			receiver_stall_pct = (phase == 2) ? 56 : (phase == 3) ? 18 : 0;
			if (phase == 2) begin
				hold_request = HOLD_CYCLES;
				for (int i = 0; i < 30; i++)
					send_packet(build_packet($urandom_range(1, 3), 16'd0, ECHO_REQUEST, 0));
			end
			phase_bytes = 0;
			while (phase_bytes < 230) begin
				send_random_packet(sent);
				phase_bytes += sent;
			end
		end

		// A packet that never sees its last byte yields no decision.
		for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
		push <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d decisions over %0d packet bytes: %0d replies, %0d short drops,",
			tracker.decisions_out, tracker.bytes_in, tracker.per_action[ACT_REPLY],
			tracker.per_action[ACT_DROP_SHORT]);
		$display("%0d echo-reply drops, %0d other-type drops; input held off by full for %0d cycles.",
			tracker.per_action[ACT_DROP_REPLY], tracker.per_action[ACT_DROP_OTHER], full_cycles);
		if (tracker.failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
				@(posedge clk);
				if (pop && !empty)
					tracker.compare_decision(action, icmp_checksum, reply_source,
						reply_destination, icmp_length);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (full) full_cycles++;
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

endmodule

### icmp_echo_responder_core.f
src/iecr_pkg.sv
src/iecr_front.sv
src/iecr_queue.sv
src/iecr_back.sv
src/icmp_echo_responder_core.sv
sim/testbench.sv
